FILE: rtl/mmf_pkg.sv
// Shared types and constants for the MIDI message framer with message queue.
// Used by the framer, the command queue, the message queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package mmf_pkg;

	// Default message queue depth.
	localparam int QUEUE_DEPTH_DEF = 32;

	// Widths fixed by the item fields.
	localparam int BYTE_W  = 8;
	localparam int DATA_W  = 7;
	localparam int LEVEL_W = 6;
	localparam int MSG_W   = BYTE_W + 2 * DATA_W;

	// A byte with this bit set (0x80) is a status byte.
	localparam int STATUS_BIT_IDX = 7;

	// Input operation codes.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Position of the next byte within a three-byte frame.
	localparam logic [1:0] FRAME_POS_FIRST  = 2'd0;
	localparam logic [1:0] FRAME_POS_SECOND = 2'd1;
	localparam logic [1:0] FRAME_POS_LAST   = 2'd2;

	// Command queue between front and back.
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_PUSH,
		CMD_POP
	} cmd_kind_t;

	// Command from the framer to the message queue.
	typedef struct packed {
		cmd_kind_t               kind;
		logic [BYTE_W-1:0]       status;
		logic [DATA_W-1:0]       data_first;
		logic [DATA_W-1:0]       data_second;
	} cmd_t;

	// One result beat from the message queue.
	typedef struct packed {
		logic                    msg_valid;
		logic [BYTE_W-1:0]       msg_status;
		logic [DATA_W-1:0]       msg_data_first;
		logic [DATA_W-1:0]       msg_data_second;
		logic                    frame_stored;
		logic                    frame_dropped;
		logic [LEVEL_W-1:0]      queue_level;
	} res_t;

endpackage

FILE: rtl/midi_message_framer_fifo_unit.sv
// Top level of the MIDI message framer with message queue: framer front,
// command queue, message queue back. Depends on mmf_pkg and the mmf_* modules.
//
//  Channel  | Beat carries                  | tdata / tuser
//  ---------+-------------------------------+------------------------------------
//  s_axis   | one received byte or a pop    | tdata: rx_byte; tuser: operation
//  m_axis   | one result per input beat     | tdata: message, flags, queue level;
//           |                               | tuser: msg_valid
//
// Throughput is one input beat per clock cycle while the command queue has room;
// each input beat yields exactly one result beat. It is registered in the command
// queue and then in the message queue's execute register before it is presented.
// Reset clears the frame assembly, pointers and counts at once; the message
// memory is not cleared, since only entries that were written are ever read.
// A stalled m_axis side fills the two-entry command queue, after which
// s_axis_tready drops; the front never waits on the back otherwise.
`timescale 1ns / 1ps

module midi_message_framer_fifo_unit #(
	parameter int QUEUE_DEPTH = mmf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] operation (0 byte, 1 pop)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] msg_status, [14:8] msg_data_first,
	                                    // [21:15] msg_data_second, [22] frame_stored,
	                                    // [23] frame_dropped, [29:24] queue_level,
	                                    // [31:30] zero
	output logic        m_axis_tuser    // [0] msg_valid
);
	import mmf_pkg::*;

	// Framer output into the command queue.
	logic  fr_cmd_valid;
	logic  fr_cmd_ready;
	cmd_t  fr_cmd;

	// Command queue output into the message queue.
	logic  q_cmd_valid;
	logic  q_cmd_ready;
	cmd_t  q_cmd;

	res_t  res;

	// The front assembles frames and tags each beat as push, pop or no action.
	mmf_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.operation (s_axis_tuser),
		.rx_byte   (s_axis_tdata),
		.cmd_valid (fr_cmd_valid),
		.cmd_ready (fr_cmd_ready),
		.cmd       (fr_cmd)
	);

	mmf_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_cmd_valid),
		.wr_ready (fr_cmd_ready),
		.wr_cmd   (fr_cmd),
		.rd_valid (q_cmd_valid),
		.rd_ready (q_cmd_ready),
		.rd_cmd   (q_cmd)
	);

	// The back decides store versus drop from its own count, so the front
	// never needs to know how full the message queue is.
	mmf_msg_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_msg_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_cmd_valid),
		.cmd_ready (q_cmd_ready),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tuser = res.msg_valid;
	assign m_axis_tdata = {2'b00, res.queue_level, res.frame_dropped, res.frame_stored,
		res.msg_data_second, res.msg_data_first, res.msg_status};

`ifndef NO_ASSERTIONS
	// A pop result never reports a frame event.
	a_pop_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[22] && !m_axis_tdata[23])
		else $error("pop result carries a frame flag");

	// Message bytes read as zero unless a message was popped.
	a_msg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[21:0] == '0)
		else $error("message bytes nonzero without a popped message");

	// A frame is dropped only when the queue stays full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[29:24] == LEVEL_W'(QUEUE_DEPTH))
		else $error("frame dropped while the queue had room");
`endif

endmodule

FILE: rtl/mmf_framer.sv
// Front part: takes input beats, assembles three-byte frames and classifies
// each beat into a queue command. Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [mmf_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          cmd_valid,
	input  logic                          cmd_ready,
	output mmf_pkg::cmd_t                 cmd
);
	import mmf_pkg::*;

	logic [1:0]        pos_q;
	logic [BYTE_W-1:0] byte0_q;
	logic [DATA_W-1:0] byte1_q;
	logic [1:0]        pos_eff;
	logic              complete;
	logic              accept_byte;

	assign in_ready    = cmd_ready;
	assign cmd_valid   = in_valid;
	assign accept_byte = in_valid && cmd_ready && (operation == OP_BYTE);

	// A status byte restarts the frame.
	assign pos_eff  = rx_byte[STATUS_BIT_IDX] ? FRAME_POS_FIRST : pos_q;
	assign complete = (pos_eff == FRAME_POS_LAST);

	always_comb begin
		cmd.status      = byte0_q;
		cmd.data_first  = byte1_q;
		cmd.data_second = rx_byte[DATA_W-1:0];
		if (operation == OP_POP) begin
			cmd.kind = CMD_POP;
		end else if (complete && byte0_q[STATUS_BIT_IDX]) begin
			cmd.kind = CMD_PUSH;
		end else begin
			cmd.kind = CMD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= FRAME_POS_FIRST;
			byte0_q <= '0;
			byte1_q <= '0;
		end else if (accept_byte) begin
			if (pos_eff == FRAME_POS_FIRST) begin
				byte0_q <= rx_byte;
			end
			if (pos_eff == FRAME_POS_SECOND) begin
				byte1_q <= rx_byte[DATA_W-1:0];
			end
			pos_q <= complete ? FRAME_POS_FIRST : pos_eff + 2'd1;
		end
	end

endmodule

FILE: rtl/mmf_cmd_fifo.sv
// Short command queue that decouples the framer from the message queue.
// Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  mmf_pkg::cmd_t  wr_cmd,
	output logic           rd_valid,
	input  logic           rd_ready,
	output mmf_pkg::cmd_t  rd_cmd
);
	import mmf_pkg::*;

	cmd_t                 slot_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign wr_ready = (count_q != CMD_CNT_W'(CMD_FIFO_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
					: wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0
					: rd_ptr_q + CMD_PTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + CMD_CNT_W'(1);
				2'b01:   count_q <= count_q - CMD_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mmf_msg_queue.sv
// Back part: executes push and pop commands on the message memory and holds
// the result beat in an output register. Depends on mmf_pkg.
`timescale 1ns / 1ps

module mmf_msg_queue #(
	parameter int QUEUE_DEPTH = mmf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  mmf_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output mmf_pkg::res_t  res
);
	import mmf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [MSG_W-1:0] mem [QUEUE_DEPTH];
	logic [MSG_W-1:0] rdata_q;
	logic [PTR_W-1:0] push_ptr_q;
	logic [PTR_W-1:0] pop_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic             valid_s1;
	logic             msg_valid_s1;
	logic             stored_s1;
	logic             dropped_s1;
	logic [CNT_W-1:0] level_s1;

	logic             exec;
	logic             do_push;
	logic             do_pop;
	logic             full;

	assign cmd_ready = !valid_s1 || res_ready;
	assign exec      = cmd_valid && cmd_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign do_push   = exec && (cmd.kind == CMD_PUSH) && !full;
	assign do_pop    = exec && (cmd.kind == CMD_POP) && (count_q != '0);

	always_comb begin
		count_d = count_q;
		if (do_push) begin
			count_d = count_q + CNT_W'(1);
		end else if (do_pop) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[push_ptr_q] <= {cmd.status, cmd.data_first, cmd.data_second};
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			rdata_q <= mem[pop_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_ptr_q   <= '0;
			pop_ptr_q    <= '0;
			count_q      <= '0;
			valid_s1     <= 1'b0;
			msg_valid_s1 <= 1'b0;
			stored_s1    <= 1'b0;
			dropped_s1   <= 1'b0;
			level_s1     <= '0;
		end else begin
			if (do_push) begin
				push_ptr_q <= (push_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: push_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				pop_ptr_q <= (pop_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: pop_ptr_q + PTR_W'(1);
			end
			count_q <= count_d;
			if (exec) begin
				valid_s1     <= 1'b1;
				msg_valid_s1 <= do_pop;
				stored_s1    <= do_push;
				dropped_s1   <= (cmd.kind == CMD_PUSH) && full;
				level_s1     <= count_d;
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign res_valid           = valid_s1;
	assign res.msg_valid       = msg_valid_s1;
	assign res.msg_status      = msg_valid_s1 ? rdata_q[MSG_W-1 -: BYTE_W] : '0;
	assign res.msg_data_first  = msg_valid_s1 ? rdata_q[2*DATA_W-1 -: DATA_W] : '0;
	assign res.msg_data_second = msg_valid_s1 ? rdata_q[DATA_W-1:0] : '0;
	assign res.frame_stored    = stored_s1;
	assign res.frame_dropped   = dropped_s1;
	assign res.queue_level     = LEVEL_W'(level_s1);

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for midi_message_framer_fifo_unit: predicts every result beat
// from its own model of the frame assembly and message queue. Depends on mmf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import mmf_pkg::*;

	localparam int DEPTH       = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int MAX_PRINTS  = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
	logic        s_axis_tuser = OP_BYTE; // [0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;         // [7:0] status, [14:8] data 1, [21:15] data 2,
	                                   // [22] stored, [23] dropped, [29:24] level
	logic        m_axis_tuser;         // [0] msg_valid

	// Model of the block: frame under assembly and the message queue.
	logic [7:0]  frame_buf [3];
	int          frame_pos;
	logic [23:0] msg_mem [DEPTH];
	int          wr_ptr;
	int          rd_ptr;
	int          msg_count;

	res_t        expected_results [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          sender_gaps_on;
	bit          receiver_stalls_on;

	midi_message_framer_fifo_unit #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Work out the result of one accepted beat and advance the model.
	function automatic res_t framer_queue_predict(input logic op, input logic [7:0] rx);
		res_t        r;
		logic [23:0] word;
		r = '0;
		if (op == OP_POP) begin
			// Popping an empty queue returns nothing and changes nothing.
			if (msg_count > 0) begin
				word              = msg_mem[rd_ptr];
				r.msg_valid       = 1'b1;
				r.msg_status      = word[23:16];
				r.msg_data_first  = word[14:8];
				r.msg_data_second = word[6:0];
				rd_ptr            = (rd_ptr + 1) % DEPTH;
				msg_count--;
			end
		end else begin
			// A status byte always starts a new frame.
			if (rx[STATUS_BIT_IDX])
				frame_pos = 0;
			frame_buf[frame_pos] = rx;
			frame_pos++;
			if (frame_pos == 3) begin
				// Frames that do not open with a status byte are thrown away quietly.
				if (frame_buf[0][STATUS_BIT_IDX]) begin
					if (msg_count < DEPTH) begin
						msg_mem[wr_ptr] = {frame_buf[0], frame_buf[1], frame_buf[2]};
						wr_ptr          = (wr_ptr + 1) % DEPTH;
						msg_count++;
						r.frame_stored  = 1'b1;
					end else begin
						r.frame_dropped = 1'b1;
					end
				end
				frame_pos = 0;
			end
		end
		r.queue_level = LEVEL_W'(msg_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_PRINTS)
			$display("MISMATCH cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Send one beat. The caller is always just past a rising edge, and tvalid is
	// only lowered in a step where it is not raised again.
	task automatic send_beat(input logic op, input logic [7:0] rx);
		if (sender_gaps_on && $urandom_range(99) < 33) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 33);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= rx;
		do @(posedge clk); while (!s_axis_tready);
		expected_results.push_back(framer_queue_predict(op, rx));
	endtask

	task automatic send_frame(input logic [7:0] status_byte, input logic [6:0] d1,
			input logic [6:0] d2);
		send_beat(OP_BYTE, status_byte);
		send_beat(OP_BYTE, {1'b0, d1});
		send_beat(OP_BYTE, {1'b0, d2});
	endtask

	// Hold the input side until every outstanding result has been checked.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic test_directed_cases();
		send_beat(OP_POP, 8'h00);                    // pop while empty
		send_frame(8'h80, 7'h00, 7'h00);             // lowest status and data
		send_frame(8'hFF, 7'h7F, 7'h7F);             // highest status and data
		send_beat(OP_BYTE, 8'h00);                   // frame without a status byte
		send_beat(OP_BYTE, 8'h55);
		send_beat(OP_BYTE, 8'h2A);
		send_beat(OP_BYTE, 8'h90);                   // status byte mid-frame restarts it
		send_beat(OP_BYTE, 8'h01);
		send_beat(OP_BYTE, 8'h91);
		send_beat(OP_BYTE, 8'h02);
		send_beat(OP_BYTE, 8'h03);
		repeat (4) send_beat(OP_POP, 8'hA5);         // three messages, then empty again
	endtask

	// Well-formed frames with random content, mixed with pops (pop_pct percent of picks),
	// stray bytes and frames cut short after the status byte or the first data byte.
	task automatic test_random_traffic(input int n_beats, input int pop_pct);
		int sent;
		int pick;
		int k;
		sent = 0;
		while (sent < n_beats) begin
			pick = $urandom_range(99);
			if (pick < pop_pct) begin
				send_beat(OP_POP, 8'($urandom));
				sent++;
			end else if (pick < 90) begin
				send_frame({1'b1, 7'($urandom)}, 7'($urandom), 7'($urandom));
				sent += 3;
			end else if (pick < 95) begin
				send_beat(OP_BYTE, 8'($urandom));
				sent++;
			end else begin
				send_beat(OP_BYTE, {1'b1, 7'($urandom)});
				k = $urandom_range(1);
				repeat (k) send_beat(OP_BYTE, {1'b0, 7'($urandom)});
				sent += 1 + k;
			end
		end
	endtask

	task automatic test_fill_to_overflow();
		test_random_traffic(200, 8);
	endtask

	task automatic test_drain_to_empty();
		test_random_traffic(150, 85);
	endtask

	task automatic test_back_to_back();
		sender_gaps_on     = 1'b0;
		receiver_stalls_on = 1'b0;
		test_random_traffic(150, 35);
		drain_results();
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// The receiver stalls about a third of the time unless stalls are switched off.
	always @(posedge clk) begin
		m_axis_tready <= receiver_stalls_on ? ($urandom_range(99) >= 33) : 1'b1;
	end

	// Every result beat is checked against the oldest expectation.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with none expected", int'(m_axis_tdata), 0);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tuser != want.msg_valid)
					report_mismatch("msg_valid", int'(m_axis_tuser),
						int'(want.msg_valid));
				if (m_axis_tdata[7:0] != want.msg_status)
					report_mismatch("msg_status", int'(m_axis_tdata[7:0]),
						int'(want.msg_status));
				if (m_axis_tdata[14:8] != want.msg_data_first)
					report_mismatch("msg_data_first", int'(m_axis_tdata[14:8]),
						int'(want.msg_data_first));
				if (m_axis_tdata[21:15] != want.msg_data_second)
					report_mismatch("msg_data_second", int'(m_axis_tdata[21:15]),
						int'(want.msg_data_second));
				if (m_axis_tdata[22] != want.frame_stored)
					report_mismatch("frame_stored", int'(m_axis_tdata[22]),
						int'(want.frame_stored));
				if (m_axis_tdata[23] != want.frame_dropped)
					report_mismatch("frame_dropped", int'(m_axis_tdata[23]),
						int'(want.frame_dropped));
				if (m_axis_tdata[29:24] != want.queue_level)
					report_mismatch("queue_level", int'(m_axis_tdata[29:24]),
						int'(want.queue_level));
				if (m_axis_tdata[31:30] != 2'b00)
					report_mismatch("tdata padding", int'(m_axis_tdata[31:30]), 0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		frame_buf          = '{8'h00, 8'h00, 8'h00};
		frame_pos          = 0;
		wr_ptr             = 0;
		rd_ptr             = 0;
		msg_count          = 0;
		sender_gaps_on     = 1'b1;
		receiver_stalls_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		drain_results();
		test_fill_to_overflow();
		drain_results();
		test_drain_to_empty();
		drain_results();
		test_back_to_back();
		test_random_traffic(280, 33);

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mmf_pkg.sv
rtl/mmf_framer.sv
rtl/mmf_cmd_fifo.sv
rtl/mmf_msg_queue.sv
rtl/midi_message_framer_fifo_unit.sv
verif/tb_top.sv
